### hdl/signed_binary_to_decimal_128_defines.svh
// Assertion macros shared by the signed binary to decimal converter.
`ifndef SIGNED_BINARY_TO_DECIMAL_128_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_128_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside of reset.
`define SBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside of reset.
`define SBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sbd_pkg.sv
// Shared constants and types of the signed binary to decimal converter.
package sbd_pkg;

    localparam int SRC_W      = 128;
    localparam int EXT_W      = 256;
    localparam int VALUE_BITS = 128;

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

    typedef logic [3:0] t_digit;

    typedef struct packed {
        logic clr;
        logic dbl;
        logic shift;
    } t_cell_ctrl;

endpackage

### hdl/sbd_cell.sv
// One BCD digit cell: clears, doubles with carry-in, or takes its lower neighbor's digit.
module sbd_cell (
    input  logic                i_clk,
    input  sbd_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_carry,
    input  sbd_pkg::t_digit     i_shift_digit,
    output sbd_pkg::t_digit     o_digit,
    output logic                o_carry
);
    import sbd_pkg::*;

    t_digit     r_digit;
    logic [4:0] w_twice;
    t_digit     n_digit;

    always_comb begin
        w_twice = {r_digit, i_carry};
        if (w_twice >= 5'd10) begin
            n_digit = 4'(w_twice - 5'd10);
        end else begin
            n_digit = w_twice[3:0];
        end
    end

    // Doubling a digit of five or more always overflows into the next cell.
    assign o_carry = (r_digit >= 4'd5);
    assign o_digit = r_digit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clr) begin
            r_digit <= '0;
        end else if (i_ctrl.dbl) begin
            r_digit <= n_digit;
        end else if (i_ctrl.shift) begin
            r_digit <= i_shift_digit;
        end
    end

endmodule

### hdl/signed_binary_to_decimal_128.sv
// The first digit is registered after the bit-serial conversion and after the suppression of any
// leading zeros; later digits follow one per cycle while the output is not stalled.
// The conversion runs as bit-serial doubling through the digit cell chain; the input is ready only
// between items, so a new item is taken only after the last digit of the previous one is emitted.
// Reset (synchronous, active low) returns to idle and drops the output valid.
`include "signed_binary_to_decimal_128_defines.svh"

// Top level: sign handling, bit-serial conversion control and digit output.
module signed_binary_to_decimal_128 (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [63:0]           i_value_high,
    input  logic [63:0]           i_value_low,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output sbd_pkg::t_digit       o_digit,
    output logic                  o_negative,
    output logic                  o_last_digit
);
    import sbd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [VALUE_BITS-1:0]   r_mag;
    logic                    r_neg;
    logic [BIT_CNT_W-1:0]    r_bits;
    logic [DIG_CNT_W-1:0]    r_left;

    logic [EXT_W-1:0]        w_ext;
    logic [VALUE_BITS-1:0]   w_val;
    logic [VALUE_BITS-1:0]   w_mag;
    logic                    w_neg;
    logic                    w_accept;
    logic                    w_load;
    t_digit                  w_top;
    t_cell_ctrl              w_ctrl;
    t_digit                  w_digit [NUM_DIGITS];
    logic                    w_carry [NUM_DIGITS];

    // Sign-extend to the widest form, then cut to the working width.
    assign w_ext = {{(EXT_W - SRC_W){i_value_high[63]}}, i_value_high, i_value_low};
    assign w_val = w_ext[VALUE_BITS-1:0];
    assign w_neg = w_val[VALUE_BITS-1];
    assign w_mag = w_neg ? ~(w_val - VALUE_BITS'(1)) : w_val;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_top      = w_digit[NUM_DIGITS-1];
    assign w_load     = (r_state == S_EMIT) && (!o_out_valid || i_out_ready);

    always_comb begin
        w_ctrl.clr   = w_accept;
        w_ctrl.dbl   = (r_state == S_CONV);
        // Digits move toward the top cell while skipping leading zeros and on each output.
        w_ctrl.shift = ((r_state == S_SKIP) && (w_top == 4'd0) && (r_left > DIG_CNT_W'(1)))
                       || w_load;
    end

    for (genvar k = 0; k < NUM_DIGITS; k++) begin : g_cell
        if (k == 0) begin : g_first
            sbd_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_carry       (r_mag[VALUE_BITS-1]),
                .i_shift_digit (4'd0),
                .o_digit       (w_digit[k]),
                .o_carry       (w_carry[k])
            );
        end else begin : g_rest
            sbd_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_carry       (w_carry[k-1]),
                .i_shift_digit (w_digit[k-1]),
                .o_digit       (w_digit[k]),
                .o_carry       (w_carry[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bits      <= '0;
            r_left      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mag   <= w_mag;
                        r_neg   <= w_neg;
                        r_bits  <= BIT_CNT_W'(VALUE_BITS);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_mag  <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    r_bits <= r_bits - BIT_CNT_W'(1);
                    if (r_bits == BIT_CNT_W'(1)) begin
                        r_left  <= DIG_CNT_W'(NUM_DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    if (w_ctrl.shift) begin
                        r_left <= r_left - DIG_CNT_W'(1);
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        o_digit      <= w_top;
                        o_negative   <= r_neg;
                        o_last_digit <= (r_left == DIG_CNT_W'(1));
                        r_left       <= r_left - DIG_CNT_W'(1);
                        if (r_left == DIG_CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SBD_ASSERT_IMP(a_no_overflow, r_state == S_CONV, !w_carry[NUM_DIGITS-1], "digit chain overflow")
    `SBD_ASSERT_IMP(a_digit_range, o_out_valid, o_digit <= 4'd9, "output digit above nine")
    `SBD_ASSERT_IMP(a_more_digits, o_out_valid && !o_last_digit, r_state == S_EMIT, "run ended early")
    `SBD_ASSERT_NXT(a_start_conv, w_accept, r_state == S_CONV && r_bits == BIT_CNT_W'(VALUE_BITS), "bad start")

endmodule
